/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_BITS  = 64;
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    // frame index of any 32-bit address, up to and including 2^20
    localparam int IDX_W      = 33 - PAGE_SHIFT;

    localparam logic [31:0] ALIGN_MASK = 32'(PAGE_BYTES - 1);
    localparam logic [31:0] BASE_RESET = 32'h0010_0000;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;
    localparam logic [1:0] OP_REGION  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NONE       = 2'd1;
    localparam logic [1:0] ST_MISALIGNED = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } map_req_t;

    // index of the lowest set bit, zero for an empty word
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                r = BIT_AW'(i);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/bfa_free_map.sv */
// ----------------------------------------------------------------------------
// bfa_free_map
// Free bitmap store: one word per row, registered read, per-row valid bits
// so that rows never written since reset read as all allocated.
// ----------------------------------------------------------------------------
module bfa_free_map
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::map_req_t             req,
    output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);

    logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::MAP_WORDS-1:0] valid_reg;
    logic [bfa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page-frame allocator over a free bitmap held in a small synchronous RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the command has finished, and the result appears on frame_addr and status in
// the cycle busy falls, flagged by done, high for a single cycle. The receiver
// cannot stall, so sample the result whenever done is high. Every bitmap word
// goes through the one RAM port pair, one word per cycle: allocate runs decode,
// a read-and-test pass over the words in order, and one write-back; reserve and
// free at an address run decode, a read and a write-back; a region free runs
// decode, the prepare steps, then a read and write-back per bitmap word it
// touches. After reset every frame is allocated; no clearing pass is needed.
// cfg_ready is always high; write base_address only while busy is low.
module bitmap_frame_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] addr,
    input  logic [31:0] region_size,
    output logic        done,
    output logic [31:0] frame_addr,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int WB = bfa_pkg::WORD_BITS;
    localparam int WA = bfa_pkg::WORD_AW;
    localparam int BA = bfa_pkg::BIT_AW;
    localparam int IW = bfa_pkg::IDX_W;
    localparam int PS = bfa_pkg::PAGE_SHIFT;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_ALLOC     = 4'd3;
    localparam logic [3:0] S_SINGLE_RD = 4'd4;
    localparam logic [3:0] S_SINGLE_WR = 4'd5;
    localparam logic [3:0] S_PREP2     = 4'd6;
    localparam logic [3:0] S_PREP3     = 4'd7;
    localparam logic [3:0] S_SWEEP     = 4'd8;

    localparam logic [32:0] ADDR_TOP  = 33'h1_0000_0000;
    localparam logic [32:0] PAGE_MASK = {21'd0, bfa_pkg::ALIGN_MASK[11:0]};
    localparam logic [IW-1:0] FRAMES  = IW'(bfa_pkg::NUM_FRAMES);

    logic [3:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   base_reg;
    logic [WA:0]   rd_w_reg, rd_w_next;
    logic          chk_v_reg, chk_v_next;
    logic [WA-1:0] chk_w_reg, chk_w_next;
    logic [WA-1:0] tgt_w_reg, tgt_w_next;
    logic [BA-1:0] bit_reg, bit_next;
    logic [WB-1:0] word_reg, word_next;
    logic [32:0]   upper_reg, upper_next;
    logic [32:0]   lo_reg, lo_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] last_reg, last_next;
    logic [WA-1:0] first_w_reg, first_w_next;
    logic [WA-1:0] last_w_reg, last_w_next;
    logic          done_reg, done_next;
    logic [31:0]   frame_reg, frame_next;
    logic [1:0]    status_reg, status_next;

    bfa_pkg::map_req_t req;
    logic [WB-1:0]     rd_data;

    // decode-time terms
    logic [31:0]   diff;
    logic [IW-1:0] sgl_idx;
    logic [IW-1:0] sgl_word;
    logic [32:0]   end_sum;
    logic [32:0]   end_sat;
    logic [31:0]   lo_max;
    logic [32:0]   lo_up;
    // region terms
    logic [32:0]   span;
    logic [32:0]   off;
    logic [IW:0]   hi_sum;
    logic [IW-1:0] hi;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] first_word;
    logic [IW-1:0] last_word;
    logic [BA-1:0] lo_b;
    logic [BA-1:0] hi_b;
    logic [WB-1:0] sweep_mask;
    // allocate terms
    logic [IW-1:0] alloc_idx;
    logic [32:0]   alloc_off;
    logic [WB-1:0] bit_mask;

    bfa_free_map u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign frame_addr = frame_reg;
    assign status     = status_reg;

    always_comb
    begin
        diff       = addr_reg - base_reg;
        sgl_idx    = {1'b0, diff[31:PS]};
        sgl_word   = sgl_idx >> BA;

        end_sum    = {1'b0, addr_reg} + {1'b0, size_reg};
        end_sat    = (end_sum > ADDR_TOP) ? ADDR_TOP : end_sum;
        lo_max     = (addr_reg > base_reg) ? addr_reg : base_reg;
        lo_up      = ({1'b0, lo_max} + PAGE_MASK) & ~PAGE_MASK;

        span       = upper_reg - lo_reg;
        off        = lo_reg - {1'b0, base_reg};

        hi_sum     = {1'b0, first_reg} + {1'b0, count_reg};
        hi         = (hi_sum > {1'b0, FRAMES}) ? FRAMES : hi_sum[IW-1:0];
        last_idx   = hi - IW'(1);
        first_word = first_reg >> BA;
        last_word  = last_idx >> BA;

        lo_b       = (chk_w_reg == first_w_reg) ? first_reg[BA-1:0] : '0;
        hi_b       = (chk_w_reg == last_w_reg) ? last_reg[BA-1:0] : '1;
        sweep_mask = ({WB{1'b1}} << lo_b) & ({WB{1'b1}} >> (BA'(WB - 1) - hi_b));

        alloc_idx  = {{(IW - WA - BA){1'b0}}, tgt_w_reg, bit_reg};
        alloc_off  = {alloc_idx, {PS{1'b0}}};
        bit_mask   = {{(WB - 1){1'b0}}, 1'b1} << bit_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        size_next    = size_reg;
        rd_w_next    = rd_w_reg;
        chk_v_next   = 1'b0;
        chk_w_next   = chk_w_reg;
        tgt_w_next   = tgt_w_reg;
        bit_next     = bit_reg;
        word_next    = word_reg;
        upper_next   = upper_reg;
        lo_next      = lo_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        first_w_next = first_w_reg;
        last_w_next  = last_w_reg;
        done_next    = 1'b0;
        frame_next   = frame_reg;
        status_next  = status_reg;
        req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    addr_next  = addr;
                    size_next  = region_size;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                frame_next = '0;
                unique case (op_reg)
                    bfa_pkg::OP_ALLOC:
                    begin
                        rd_w_next  = '0;
                        state_next = S_SCAN;
                    end
                    bfa_pkg::OP_RESERVE, bfa_pkg::OP_FREE:
                    begin
                        tgt_w_next = sgl_word[WA-1:0];
                        bit_next   = sgl_idx[BA-1:0];
                        if ((addr_reg & bfa_pkg::ALIGN_MASK) != '0)
                        begin
                            status_next = bfa_pkg::ST_MISALIGNED;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (addr_reg < base_reg || sgl_idx >= FRAMES)
                        begin
                            status_next = bfa_pkg::ST_RANGE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SINGLE_RD;
                        end
                    end
                    bfa_pkg::OP_REGION:
                    begin
                        upper_next = end_sat & ~PAGE_MASK;
                        lo_next    = lo_up;
                        state_next = S_PREP2;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // read the next word while testing the one read last cycle
                if (rd_w_reg < (WA + 1)'(bfa_pkg::MAP_WORDS))
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_w_reg[WA-1:0];
                    rd_w_next   = rd_w_reg + (WA + 1)'(1);
                    chk_v_next  = 1'b1;
                    chk_w_next  = rd_w_reg[WA-1:0];
                end
                if (chk_v_reg)
                begin
                    if (rd_data != '0)
                    begin
                        tgt_w_next = chk_w_reg;
                        bit_next   = bfa_pkg::lowest_set(rd_data);
                        word_next  = rd_data;
                        chk_v_next = 1'b0;
                        state_next = S_ALLOC;
                    end
                    else if (chk_w_reg == WA'(bfa_pkg::MAP_WORDS - 1))
                    begin
                        status_next = bfa_pkg::ST_NONE;
                        done_next   = 1'b1;
                        chk_v_next  = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_ALLOC:
            begin
                if (alloc_idx < FRAMES)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = tgt_w_reg;
                    req.wr_data = word_reg & ~bit_mask;
                    frame_next  = base_reg + alloc_off[31:0];
                    status_next = bfa_pkg::ST_OK;
                end
                else
                begin
                    status_next = bfa_pkg::ST_NONE;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SINGLE_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = tgt_w_reg;
                state_next  = S_SINGLE_WR;
            end

            S_SINGLE_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = tgt_w_reg;
                req.wr_data = (op_reg == bfa_pkg::OP_FREE) ? (rd_data | bit_mask)
                                                           : (rd_data & ~bit_mask);
                status_next = bfa_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_PREP2:
            begin
                count_next = span[32:PS];
                first_next = off[32:PS];
                if (upper_reg <= lo_reg)
                begin
                    status_next = bfa_pkg::ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_PREP3;
                end
            end

            S_PREP3:
            begin
                last_next    = last_idx;
                first_w_next = first_word[WA-1:0];
                last_w_next  = last_word[WA-1:0];
                rd_w_next    = {1'b0, first_word[WA-1:0]};
                if (first_reg >= FRAMES)
                begin
                    status_next = bfa_pkg::ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end

            S_SWEEP:
            begin
                // rows are distinct, so the write-back never meets the read
                if (rd_w_reg <= {1'b0, last_w_reg})
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_w_reg[WA-1:0];
                    rd_w_next   = rd_w_reg + (WA + 1)'(1);
                    chk_v_next  = 1'b1;
                    chk_w_next  = rd_w_reg[WA-1:0];
                end
                if (chk_v_reg)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = chk_w_reg;
                    req.wr_data = rd_data | sweep_mask;
                    if (chk_w_reg == last_w_reg)
                    begin
                        status_next = bfa_pkg::ST_OK;
                        done_next   = 1'b1;
                        chk_v_next  = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            base_reg    <= bfa_pkg::BASE_RESET;
            rd_w_reg    <= '0;
            chk_v_reg   <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= bfa_pkg::ST_OK;
            frame_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_w_reg    <= rd_w_next;
            chk_v_reg   <= chk_v_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            frame_reg   <= frame_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        size_reg    <= size_next;
        chk_w_reg   <= chk_w_next;
        tgt_w_reg   <= tgt_w_next;
        bit_reg     <= bit_next;
        word_reg    <= word_next;
        upper_reg   <= upper_next;
        lo_reg      <= lo_next;
        first_reg   <= first_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
        first_w_reg <= first_w_next;
        last_w_reg  <= last_w_next;
    end

endmodule
